// ===== design/tfn_pkg.sv =====
// shared widths, stage counts and types for the triangle face normal core
package tfn_pkg;

  localparam int CoordW    = 16;
  localparam int EdgeW     = CoordW + 1;
  localparam int ProdW     = 2 * EdgeW;
  localparam int CrossW    = ProdW + 1;
  localparam int MagW      = ProdW;
  localparam int HalfW     = MagW / 2;
  localparam int SqW       = 2 * MagW;
  localparam int RadW      = SqW + 2;
  localparam int RootW     = RadW / 2;
  localparam int RemW      = RootW + 1;
  localparam int FracW     = 14;
  localparam int QuotW     = FracW + 1;
  localparam int NumW      = MagW + FracW + 1;
  localparam int OutW      = 16;
  localparam int FrontStg  = 6;
  localparam int SqrtStg   = RootW;
  localparam int DivStg    = QuotW;
  localparam int Latency   = FrontStg + SqrtStg + 1 + DivStg + 1;

  typedef struct packed {
    logic [2:0]           neg;
    logic [2:0][MagW-1:0] mag;
    logic                 degen;
  } comp_t;

endpackage

// ===== design/triangle_face_normal_core.sv =====
// triangle face normal core: pipelined cross product, square root and divide
//
// one triangle (three corners, signed q8.8) is taken at each rising edge where
// start is high and busy is low; busy is always low, so an item can enter in
// every cycle. each item gives one result: a unit normal in signed q1.14 and
// a degenerate flag, set with a zero normal when the cross product is zero.
// the result sits on the output ports for one cycle, marked by done, and
// throughput is one item per cycle.
// the pipeline is 6 front stages (edges, products, cross and magnitude,
// split squares, squares, sum), 35 square root stages of one root bit each,
// one numerator stage and 15 divider stages of one quotient bit each,
// and the output register.
// reset clears the valid bits only; items in flight are dropped.
// the receiver cannot stall, so the pipeline never holds.
module triangle_face_normal_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [tfn_pkg::CoordW-1:0] first_x,
  input  logic signed [tfn_pkg::CoordW-1:0] first_y,
  input  logic signed [tfn_pkg::CoordW-1:0] first_z,
  input  logic signed [tfn_pkg::CoordW-1:0] second_x,
  input  logic signed [tfn_pkg::CoordW-1:0] second_y,
  input  logic signed [tfn_pkg::CoordW-1:0] second_z,
  input  logic signed [tfn_pkg::CoordW-1:0] third_x,
  input  logic signed [tfn_pkg::CoordW-1:0] third_y,
  input  logic signed [tfn_pkg::CoordW-1:0] third_z,
  output logic                              done,
  output logic signed [tfn_pkg::OutW-1:0]   normal_x,
  output logic signed [tfn_pkg::OutW-1:0]   normal_y,
  output logic signed [tfn_pkg::OutW-1:0]   normal_z,
  output logic                              degenerate
);
  import tfn_pkg::*;

  logic [Latency-1:0] vld;

  logic signed [EdgeW-1:0] e1 [3];
  logic signed [EdgeW-1:0] e2 [3];
  logic signed [ProdW-1:0] pa [3];
  logic signed [ProdW-1:0] pb [3];
  comp_t                   cmp3, cmp4, cmp5, cmp6;
  logic [ProdW-1:0]        hh [3];
  logic [ProdW-1:0]        hl [3];
  logic [ProdW-1:0]        ll [3];
  logic [SqW-1:0]          sq [3];
  logic [RadW-1:0]         sum_s;

  logic [RadW-1:0]  rt_rad  [0:SqrtStg];
  logic [RemW-1:0]  rt_rem  [0:SqrtStg];
  logic [RootW-1:0] rt_root [0:SqrtStg];
  comp_t            rt_cmp  [0:SqrtStg];

  logic [2:0][NumW-1:0]  dv_rem  [0:DivStg];
  logic [2:0][QuotW-1:0] dv_q    [0:DivStg];
  logic [RootW-1:0]      dv_root [0:DivStg];
  comp_t                 dv_cmp  [0:DivStg];

  assign busy = 1'b0;
  assign done = vld[Latency-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Latency-2:0], start & ~busy};
    end
  end

  // edges from the first corner
  always_ff @(posedge clk) begin
    e1[0] <= EdgeW'(second_x) - EdgeW'(first_x);
    e1[1] <= EdgeW'(second_y) - EdgeW'(first_y);
    e1[2] <= EdgeW'(second_z) - EdgeW'(first_z);
    e2[0] <= EdgeW'(third_x) - EdgeW'(first_x);
    e2[1] <= EdgeW'(third_y) - EdgeW'(first_y);
    e2[2] <= EdgeW'(third_z) - EdgeW'(first_z);
  end

  // cross product terms
  always_ff @(posedge clk) begin
    pa[0] <= e1[1] * e2[2];
    pb[0] <= e1[2] * e2[1];
    pa[1] <= e1[2] * e2[0];
    pb[1] <= e1[0] * e2[2];
    pa[2] <= e1[0] * e2[1];
    pb[2] <= e1[1] * e2[0];
  end

  // cross product, sign and magnitude
  always_ff @(posedge clk) begin
    logic signed [CrossW-1:0] c;
    logic                     nz;
    nz = 1'b0;
    for (int i = 0; i < 3; i++) begin
      c = CrossW'(pa[i]) - CrossW'(pb[i]);
      cmp3.neg[i] <= c[CrossW-1];
      cmp3.mag[i] <= c[CrossW-1] ? MagW'(-c) : MagW'(c);
      nz = nz | (c != '0);
    end
    cmp3.degen <= ~nz;
  end

  // partial products of each square
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      hh[i] <= cmp3.mag[i][MagW-1:HalfW] * cmp3.mag[i][MagW-1:HalfW];
      hl[i] <= cmp3.mag[i][MagW-1:HalfW] * cmp3.mag[i][HalfW-1:0];
      ll[i] <= cmp3.mag[i][HalfW-1:0] * cmp3.mag[i][HalfW-1:0];
    end
    cmp4 <= cmp3;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq[i] <= (SqW'(hh[i]) << MagW) + (SqW'(hl[i]) << (HalfW + 1)) + SqW'(ll[i]);
    end
    cmp5 <= cmp4;
  end

  always_ff @(posedge clk) begin
    sum_s <= RadW'(sq[0]) + RadW'(sq[1]) + RadW'(sq[2]);
    cmp6  <= cmp5;
  end

  // square root, one root bit per stage
  assign rt_rad[0]  = sum_s;
  assign rt_rem[0]  = '0;
  assign rt_root[0] = '0;
  assign rt_cmp[0]  = cmp6;

  for (genvar k = 1; k <= SqrtStg; k++) begin : g_sqrt
    logic [RemW+1:0] rem_sh;
    logic [RemW+1:0] trial;
    logic            take;
    always_comb begin
      rem_sh = {rt_rem[k-1], rt_rad[k-1][RadW-1 -: 2]};
      trial  = {1'b0, rt_root[k-1], 2'b01};
      take   = rem_sh >= trial;
    end
    always_ff @(posedge clk) begin
      rt_rem[k]  <= take ? RemW'(rem_sh - trial) : RemW'(rem_sh);
      rt_root[k] <= {rt_root[k-1][RootW-2:0], take};
      rt_rad[k]  <= rt_rad[k-1] << 2;
      rt_cmp[k]  <= rt_cmp[k-1];
    end
  end

  // numerator with half the root for rounding
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= (NumW'(rt_cmp[SqrtStg].mag[i]) << FracW)
                      + NumW'(rt_root[SqrtStg] >> 1);
    end
    dv_q[0]    <= '0;
    dv_root[0] <= rt_root[SqrtStg];
    dv_cmp[0]  <= rt_cmp[SqrtStg];
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 1; k <= DivStg; k++) begin : g_div
    localparam int Sh = DivStg - k;
    logic [NumW:0] dsr;
    logic [2:0]    take;
    always_comb begin
      dsr = (NumW + 1)'(dv_root[k-1]) << Sh;
      for (int i = 0; i < 3; i++) begin
        take[i] = {1'b0, dv_rem[k-1][i]} >= dsr;
      end
    end
    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[k][i] <= take[i] ? NumW'({1'b0, dv_rem[k-1][i]} - dsr) : dv_rem[k-1][i];
        dv_q[k][i]   <= {dv_q[k-1][i][QuotW-2:0], take[i]};
      end
      dv_root[k] <= dv_root[k-1];
      dv_cmp[k]  <= dv_cmp[k-1];
    end
  end

  // sign and degenerate override
  always_ff @(posedge clk) begin
    logic [OutW-1:0] n [3];
    for (int i = 0; i < 3; i++) begin
      n[i] = dv_cmp[DivStg].neg[i] ? -OutW'(dv_q[DivStg][i]) : OutW'(dv_q[DivStg][i]);
      if (dv_cmp[DivStg].degen) begin
        n[i] = '0;
      end
    end
    normal_x   <= n[0];
    normal_y   <= n[1];
    normal_z   <= n[2];
    degenerate <= dv_cmp[DivStg].degen;
  end

  a_latency : assert property (@(posedge clk) disable iff (rst)
    start |-> ##(Latency) done)
    else $error("item taken without result after pipeline latency");

  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("degenerate item with nonzero normal");

  a_unit_range : assert property (@(posedge clk) disable iff (rst)
    done && !degenerate |->
      normal_x >= -16'sd16384 && normal_x <= 16'sd16384 &&
      normal_y >= -16'sd16384 && normal_y <= 16'sd16384 &&
      normal_z >= -16'sd16384 && normal_z <= 16'sd16384 &&
      !(normal_x == '0 && normal_y == '0 && normal_z == '0))
    else $error("normal component out of unit range");

endmodule

// ===== tb/triangle_face_normal_core_tb.sv =====
// testbench for the triangle face normal core: random and corner triangles against a predictor
`timescale 1ns / 100ps

module triangle_face_normal_core_tb;
  import tfn_pkg::*;

  typedef struct {
    logic signed [CoordW-1:0] c [9];
  } tri_t;

  typedef struct {
    logic signed [OutW-1:0] n [3];
    logic                   degen;
  } norm_t;

  localparam int WatchLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, degenerate;
  logic signed [CoordW-1:0] coord [9] = '{default: '0};
  logic signed [OutW-1:0] normal_x, normal_y, normal_z;

  tri_t  pending_tris [$];
  norm_t expected_normals [$];
  int    mismatch_count = 0;
  int    idle_cycles = 0;
  int    gap_left = 0;
  bit    hold_for_drain = 1'b0;
  bit    feeding_done = 1'b0;

  triangle_face_normal_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .first_x(coord[0]), .first_y(coord[1]), .first_z(coord[2]),
    .second_x(coord[3]), .second_y(coord[4]), .second_z(coord[5]),
    .third_x(coord[6]), .third_y(coord[7]), .third_z(coord[8]),
    .done(done), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .degenerate(degenerate)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [35:0] floor_sqrt(logic [71:0] s);
    logic [35:0] r;
    logic [35:0] t;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      t = r | (36'd1 << b);
      if ({36'd0, t} * {36'd0, t} <= s) r = t;
    end
    return r;
  endfunction

  function automatic norm_t face_normal(tri_t t);
    norm_t res;
    logic signed [63:0] e1 [3];
    logic signed [63:0] e2 [3];
    logic signed [63:0] cr [3];
    logic [71:0] sum;
    logic [63:0] mag, root, q;
    for (int k = 0; k < 3; k++) begin
      e1[k] = 64'(t.c[3+k]) - 64'(t.c[k]);
      e2[k] = 64'(t.c[6+k]) - 64'(t.c[k]);
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    res.degen = (cr[0] == 0 && cr[1] == 0 && cr[2] == 0);
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      mag = (cr[k] < 0) ? -cr[k] : cr[k];
      sum += 72'(mag) * 72'(mag);
    end
    root = 64'(floor_sqrt(sum));
    if (root == 0) root = 1;
    for (int k = 0; k < 3; k++) begin
      mag = (cr[k] < 0) ? -cr[k] : cr[k];
      q = (mag * 64'd16384 + (root >> 1)) / root;
      res.n[k] = res.degen ? '0 : OutW'((cr[k] < 0) ? -q : q);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [CoordW-1:0] random_coord(int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return CoordW'($urandom_range(0, 64)) - 16'd32;
      default: return CoordW'($urandom);
    endcase
  endfunction

  task automatic push_tri(tri_t t);
    pending_tris.insert(pending_tris.size(), t);
  endtask

  initial begin
    tri_t t;
    int mode;
    for (int k = 0; k < 9; k++) t.c[k] = '0;
    push_tri(t);
    for (int k = 0; k < 9; k++) t.c[k] = 16'h8000;
    push_tri(t);
    for (int k = 0; k < 9; k++) t.c[k] = 16'h7fff;
    push_tri(t);
    for (int k = 0; k < 9; k++) t.c[k] = '0;
    t.c[3] = 16'h0100; t.c[7] = 16'h0100;
    push_tri(t);
    t.c[7] = '0; t.c[8] = 16'h0100;
    push_tri(t);
    t.c[3] = '0; t.c[4] = 16'h0100; t.c[6] = 16'h0100;
    push_tri(t);
    for (int k = 0; k < 9; k++) t.c[k] = '0;
    t.c[0] = 16'h8000; t.c[1] = 16'h8000; t.c[2] = 16'h8000;
    t.c[3] = 16'h7fff; t.c[7] = 16'h7fff; t.c[8] = 16'h8000;
    push_tri(t);
    t.c[0] = 16'h7fff; t.c[3] = 16'h8000; t.c[4] = 16'h7fff;
    t.c[6] = 16'h7fff; t.c[7] = 16'h8000; t.c[8] = 16'h7fff;
    push_tri(t);
    for (int k = 0; k < 9; k++) t.c[k] = CoordW'($urandom);
    for (int k = 0; k < 3; k++) t.c[6+k] = t.c[3+k];
    push_tri(t);
    for (int k = 0; k < 3; k++) t.c[6+k] = 16'(2 * t.c[3+k] - t.c[k]);
    push_tri(t);
    for (int k = 0; k < 9; k++) t.c[k] = 16'h0001 << (k % 3);
    push_tri(t);
    for (int i = 0; i < 1750; i++) begin
      mode = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++)
        t.c[k] = (mode == 0) ? random_coord($urandom_range(0, 3))
               : (mode == 1) ? random_coord(2) : random_coord(3);
      if (mode == 2) for (int k = 0; k < 3; k++) t.c[6+k] = t.c[k];
      push_tri(t);
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_normals.insert(expected_normals.size(),
                              face_normal(pending_tris.pop_front()));
      if (pending_tris.size() == 300 && !hold_for_drain) hold_for_drain = 1'b1;
      if (pending_tris.size() == 0) begin
        start <= 1'b0;
        feeding_done = 1'b1;
      end else if ($urandom_range(0, 3) == 0 || hold_for_drain) begin
        start <= 1'b0;
        gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                : $urandom_range(1, 3);
      end else begin
        for (int k = 0; k < 9; k++) coord[k] <= pending_tris[0].c[k];
      end
    end else if (!start && pending_tris.size() != 0) begin
      if (hold_for_drain && expected_normals.size() != 0) begin
      end else if (gap_left > 0) begin
        gap_left--;
        if (hold_for_drain) hold_for_drain = 1'b0;
      end else begin
        if (hold_for_drain) hold_for_drain = 1'b0;
        for (int k = 0; k < 9; k++) coord[k] <= pending_tris[0].c[k];
        start <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    norm_t want;
    if (!rst && done) begin
      if (expected_normals.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_normals.pop_front();
        if (normal_x !== want.n[0]) report_mismatch("normal_x", normal_x, want.n[0]);
        if (normal_y !== want.n[1]) report_mismatch("normal_y", normal_y, want.n[1]);
        if (normal_z !== want.n[2]) report_mismatch("normal_z", normal_z, want.n[2]);
        if (degenerate !== want.degen)
          report_mismatch("degenerate", degenerate, want.degen);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (feeding_done && expected_normals.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tfn_pkg.sv
design/triangle_face_normal_core.sv
tb/triangle_face_normal_core_tb.sv
